// ----- hw/rtl/ghsa_pkg.sv -----
// Shared types, constants and microcode ROM for the generation handle slot allocator.
package ghsa_pkg;

   localparam int unsigned DEFAULT_SLOTS = 64;
   localparam int unsigned OP_W          = 2;
   localparam int unsigned HANDLE_W      = 31;
   localparam int unsigned INDEX_FIELD_W = 16;
   localparam int unsigned SERIAL_W      = 15;
   localparam int unsigned SLOT_OUT_W    = 6;
   localparam int unsigned HW_OUT_W      = 7;
   localparam int unsigned WIDE_W        = INDEX_FIELD_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_LOAD,
      ST_ADD_SCAN,
      ST_ADD_TEST,
      ST_ADD_COMMIT,
      ST_DEL_FREE,
      ST_DEL_DESC,
      ST_DEL_DONE,
      ST_LKP_TEST,
      ST_LKP_DONE,
      ST_FAIL
   } step_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_HINT,
      PTR_INC,
      PTR_DEC,
      PTR_HWM
   } ptr_sel_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_START,
      C_SCAN_STOP,
      C_PTR_END,
      C_BAD_HANDLE,
      C_DESC_STOP
   } cond_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_FAIL,
      RSP_ADD,
      RSP_DELETE,
      RSP_LOOKUP
   } resp_type;

   typedef struct packed {
      ptr_sel_type ptr_sel;
      logic        commit_add;
      logic        free_slot;
      logic        set_hwm;
      resp_type    resp;
      cond_type    cond;
      logic        stay;
      logic        dispatch;
      step_type    target;
   } ctrl_word_type;

   typedef struct packed {
      logic        latch;
      ptr_sel_type ptr_sel;
      logic        commit_add;
      logic        free_slot;
      logic        set_hwm;
      resp_type    resp;
   } dp_ctrl_type;

   typedef struct packed {
      logic scan_stop;
      logic ptr_end;
      logic bad_handle;
      logic desc_stop;
   } dp_status_type;

   localparam ctrl_word_type CW_NOP = '{
      ptr_sel:    PTR_HOLD,
      commit_add: 1'b0,
      free_slot:  1'b0,
      set_hwm:    1'b0,
      resp:       RSP_NONE,
      cond:       C_NEVER,
      stay:       1'b0,
      dispatch:   1'b0,
      target:     ST_IDLE
   };

   // Actions fire when the jump is not taken, or when cond is C_ALWAYS.
   function automatic ctrl_word_type ucode_word(input step_type s);
      ctrl_word_type w;
      w = CW_NOP;
      case (s)
         ST_IDLE: begin
            w.cond     = C_START;
            w.stay     = 1'b1;
            w.dispatch = 1'b1;
         end
         ST_ADD_LOAD: begin
            w.ptr_sel = PTR_HINT;
         end
         ST_ADD_SCAN: begin
            w.cond    = C_SCAN_STOP;
            w.target  = ST_ADD_TEST;
            w.ptr_sel = PTR_INC;
            w.stay    = 1'b1;
         end
         ST_ADD_TEST: begin
            w.cond   = C_PTR_END;
            w.target = ST_FAIL;
         end
         ST_ADD_COMMIT: begin
            w.commit_add = 1'b1;
            w.resp       = RSP_ADD;
            w.cond       = C_ALWAYS;
            w.target     = ST_IDLE;
         end
         ST_DEL_FREE: begin
            w.cond      = C_BAD_HANDLE;
            w.target    = ST_FAIL;
            w.free_slot = 1'b1;
            w.ptr_sel   = PTR_HWM;
         end
         ST_DEL_DESC: begin
            w.cond    = C_DESC_STOP;
            w.target  = ST_DEL_DONE;
            w.ptr_sel = PTR_DEC;
            w.stay    = 1'b1;
         end
         ST_DEL_DONE: begin
            w.set_hwm = 1'b1;
            w.resp    = RSP_DELETE;
            w.cond    = C_ALWAYS;
            w.target  = ST_IDLE;
         end
         ST_LKP_TEST: begin
            w.cond   = C_BAD_HANDLE;
            w.target = ST_FAIL;
         end
         ST_LKP_DONE: begin
            w.resp   = RSP_LOOKUP;
            w.cond   = C_ALWAYS;
            w.target = ST_IDLE;
         end
         ST_FAIL: begin
            w.resp   = RSP_FAIL;
            w.cond   = C_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.cond   = C_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic step_type dispatch_step(input logic [OP_W-1:0] op);
      step_type s;
      case (op)
         OP_ADD:    s = ST_ADD_LOAD;
         OP_DELETE: s = ST_DEL_FREE;
         OP_LOOKUP: s = ST_LKP_TEST;
         default:   s = ST_FAIL;
      endcase
      return s;
   endfunction

endpackage

// ----- hw/rtl/ghsa_ucode_seq.sv -----
// Microcode sequencer: step counter, ROM word fetch, condition test and jump logic.
module ghsa_ucode_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ghsa_pkg::OP_W-1:0]      req_op,
   input  ghsa_pkg::dp_status_type        status,
   output logic                           busy,
   output ghsa_pkg::dp_ctrl_type          ctrl
);
   import ghsa_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw;
   logic          taken;
   logic          fire;
   logic          accept;

   assign cw     = ucode_word(step_ff);
   assign busy   = (step_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      case (cw.cond)
         C_NEVER:      taken = 1'b0;
         C_ALWAYS:     taken = 1'b1;
         C_START:      taken = start;
         C_SCAN_STOP:  taken = status.scan_stop;
         C_PTR_END:    taken = status.ptr_end;
         C_BAD_HANDLE: taken = status.bad_handle;
         C_DESC_STOP:  taken = status.desc_stop;
         default:      taken = 1'b0;
      endcase
   end

   assign fire = (cw.cond == C_ALWAYS) || !taken;

   // next step
   always_comb begin
      if (taken) begin
         step_in = cw.dispatch ? dispatch_step(req_op) : cw.target;
      end else if (cw.stay) begin
         step_in = step_ff;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   // issued controls
   always_comb begin
      ctrl.latch      = accept;
      ctrl.ptr_sel    = fire ? cw.ptr_sel : PTR_HOLD;
      ctrl.commit_add = fire && cw.commit_add;
      ctrl.free_slot  = fire && cw.free_slot;
      ctrl.set_hwm    = fire && cw.set_hwm;
      ctrl.resp       = fire ? cw.resp : RSP_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not start a sequence");

   a_resp_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (ctrl.resp != RSP_NONE) |=> !busy)
      else $error("sequence did not return to idle after its response");

endmodule

// ----- hw/rtl/ghsa_datapath.sv -----
// Datapath: slot live bits, serial memory, hint, high-water mark, scan pointer, response regs.
module ghsa_datapath #(
   parameter int unsigned SLOTS = ghsa_pkg::DEFAULT_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ghsa_pkg::dp_ctrl_type             ctrl,
   input  logic [ghsa_pkg::HANDLE_W-1:0]     req_handle,
   output ghsa_pkg::dp_status_type           status,
   output logic                              rsp_strobe,
   output logic                              rsp_ok,
   output logic [ghsa_pkg::HANDLE_W-1:0]     rsp_new_handle,
   output logic [ghsa_pkg::SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic [ghsa_pkg::HW_OUT_W-1:0]     rsp_high_water
);
   import ghsa_pkg::*;

   localparam int unsigned IDX_W = $clog2(SLOTS);
   localparam int unsigned CNT_W = $clog2(SLOTS + 1);

   logic [SLOTS-1:0]          live_ff;
   logic [SERIAL_W-1:0]       serial_mem [SLOTS];
   logic [SERIAL_W-1:0]       rd_ff;
   logic [HANDLE_W-1:0]       handle_ff;
   logic [IDX_W-1:0]          hint_ff;
   logic [CNT_W-1:0]          hwm_ff;
   logic [CNT_W-1:0]          hwm_in;
   logic [CNT_W-1:0]          ptr_ff;
   logic [CNT_W-1:0]          ptr_in;
   logic [SERIAL_W-1:0]       serial_ff;
   logic [SERIAL_W-1:0]       serial_in;

   logic                      rsp_strobe_ff;
   logic                      rsp_ok_ff;
   logic [HANDLE_W-1:0]       rsp_new_handle_ff;
   logic [SLOT_OUT_W-1:0]     rsp_slot_index_ff;
   logic [HW_OUT_W-1:0]       rsp_high_water_ff;

   logic [INDEX_FIELD_W-1:0]  hidx16;
   logic [SERIAL_W-1:0]       hser;
   logic [IDX_W-1:0]          hidx;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          ptr_idx;
   logic [CNT_W-1:0]          ptr_m1;
   logic [CNT_W-1:0]          ptr_p1;
   logic [WIDE_W-1:0]         ptr_wide;
   logic [WIDE_W-1:0]         hwm_wide;
   logic                      idx_ok;

   assign hidx16   = handle_ff[INDEX_FIELD_W-1:0];
   assign hser     = handle_ff[HANDLE_W-1:INDEX_FIELD_W];
   assign hidx     = handle_ff[IDX_W-1:0];
   assign rd_addr  = ctrl.latch ? req_handle[IDX_W-1:0] : hidx;
   assign ptr_idx  = ptr_ff[IDX_W-1:0];
   assign ptr_m1   = ptr_ff - CNT_W'(1);
   assign ptr_p1   = ptr_ff + CNT_W'(1);
   assign ptr_wide = WIDE_W'(ptr_ff);
   assign hwm_wide = WIDE_W'(hwm_in);
   assign idx_ok   = {1'b0, hidx16} < WIDE_W'(SLOTS);
   assign serial_in = serial_ff + SERIAL_W'(1);

   always_comb begin
      status.ptr_end    = (ptr_ff == CNT_W'(SLOTS));
      status.scan_stop  = status.ptr_end || !live_ff[ptr_idx];
      status.bad_handle = !idx_ok || !live_ff[hidx] || (rd_ff != hser);
      status.desc_stop  = (ptr_ff <= CNT_W'(1)) || live_ff[ptr_m1[IDX_W-1:0]];
   end

   always_comb begin
      case (ctrl.ptr_sel)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_HINT: ptr_in = CNT_W'(hint_ff);
         PTR_INC:  ptr_in = ptr_p1;
         PTR_DEC:  ptr_in = ptr_m1;
         PTR_HWM:  ptr_in = hwm_ff;
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      hwm_in = hwm_ff;
      if (ctrl.commit_add && (hwm_ff < ptr_p1)) begin
         hwm_in = ptr_p1;
      end else if (ctrl.set_hwm) begin
         hwm_in = ptr_ff;
      end
   end

   // serial store, registered read
   always_ff @(posedge clock) begin
      if (ctrl.commit_add) begin
         serial_mem[ptr_idx] <= serial_in;
      end
      rd_ff <= serial_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctrl.latch) begin
         handle_ff <= req_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff   <= '0;
         hint_ff   <= '0;
         hwm_ff    <= '0;
         serial_ff <= '0;
      end else begin
         hwm_ff <= hwm_in;
         if (ctrl.commit_add) begin
            live_ff[ptr_idx] <= 1'b1;
            hint_ff          <= ptr_idx;
            serial_ff        <= serial_in;
         end
         if (ctrl.free_slot) begin
            live_ff[hidx] <= 1'b0;
            if (hidx < hint_ff) begin
               hint_ff <= hidx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (ctrl.resp != RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      rsp_high_water_ff <= hwm_wide[HW_OUT_W-1:0];
      case (ctrl.resp)
         RSP_ADD: begin
            rsp_ok_ff         <= 1'b1;
            rsp_new_handle_ff <= {serial_in, ptr_wide[INDEX_FIELD_W-1:0]};
            rsp_slot_index_ff <= ptr_wide[SLOT_OUT_W-1:0];
         end
         RSP_LOOKUP: begin
            rsp_ok_ff         <= 1'b1;
            rsp_new_handle_ff <= '0;
            rsp_slot_index_ff <= hidx16[SLOT_OUT_W-1:0];
         end
         RSP_DELETE: begin
            rsp_ok_ff         <= 1'b1;
            rsp_new_handle_ff <= '0;
            rsp_slot_index_ff <= '0;
         end
         default: begin
            rsp_ok_ff         <= 1'b0;
            rsp_new_handle_ff <= '0;
            rsp_slot_index_ff <= '0;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_new_handle = rsp_new_handle_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_high_water = rsp_high_water_ff;

   a_hwm_in_range: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= CNT_W'(SLOTS))
      else $error("high-water mark beyond table");

   a_commit_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit_add |-> (ptr_ff < CNT_W'(SLOTS)) && !live_ff[ptr_idx])
      else $error("add committed to a live or missing slot");

   a_fail_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ok_ff) |-> (rsp_new_handle_ff == '0) &&
                                         (rsp_slot_index_ff == '0))
      else $error("failed word carries a handle or slot");

endmodule

// ----- hw/rtl/generation_handle_slot_allocator.sv -----
// Generation handle slot allocator: hands out, checks and frees serial-tagged slot handles.
//
// Input channel: a command word (req_op, req_handle) is taken at a rising edge with start
// high and busy low. req_op selects add, delete or lookup; req_handle carries the serial
// in bits 30..16 and the slot index in bits 15..0 and is ignored for add.
// Result channel: one result word per command, shown for one cycle with rsp_strobe high:
// rsp_ok, rsp_new_handle, rsp_slot_index and rsp_high_water. The receiver cannot stall;
// the word must be taken in that cycle.
// Steps after accept: lookup tests the handle, then answers; an unknown op goes straight to
// the fail step; add loads the first-open hint, steps over live slots, tests for a full table
// and commits; delete frees a slot whose handle checks, then lowers the mark. The scan
// and the descent test one live bit per cycle in the sequencer loop; busy stays high until
// the strobe cycle, in which a new command may already be taken.
// Reset clears all live bits, the hint, the high-water mark and the serial counter; no
// clearing pass is needed and start is taken in the first cycle after reset.
module generation_handle_slot_allocator #(
   parameter int unsigned SLOTS = ghsa_pkg::DEFAULT_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ghsa_pkg::OP_W-1:0]         req_op,
   input  logic [ghsa_pkg::HANDLE_W-1:0]     req_handle,
   output logic                              rsp_strobe,
   output logic                              rsp_ok,
   output logic [ghsa_pkg::HANDLE_W-1:0]     rsp_new_handle,
   output logic [ghsa_pkg::SLOT_OUT_W-1:0]   rsp_slot_index,
   output logic [ghsa_pkg::HW_OUT_W-1:0]     rsp_high_water
);
   import ghsa_pkg::*;

   dp_ctrl_type   ctrl;
   dp_status_type status;

   ghsa_ucode_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   ghsa_datapath #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .req_handle     (req_handle),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_new_handle (rsp_new_handle),
      .rsp_slot_index (rsp_slot_index),
      .rsp_high_water (rsp_high_water)
   );

endmodule

// ----- tb/generation_handle_slot_allocator_tb.sv -----
// Testbench for the generation handle slot allocator: queued commands, result checking.
`timescale 1ns / 100ps

module generation_handle_slot_allocator_tb;
   import ghsa_pkg::*;

   localparam int unsigned SLOTS       = DEFAULT_SLOTS;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;
   localparam int CYCLE_LIMIT          = 4_000_000;
   localparam int DRAIN_CYCLES         = 80;
   localparam int ROLL_PAIRS           = 60;
   localparam int MAX_REPORTS          = 50;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [HANDLE_W-1:0] handle;
   } cmd_word_type;

   typedef struct packed {
      logic                  ok;
      logic [HANDLE_W-1:0]   new_handle;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [HW_OUT_W-1:0]   high_water;
   } rsp_word_type;

   typedef struct packed {
      logic [SLOTS-1:0]               live;
      logic [SLOTS-1:0][SERIAL_W-1:0] serial;
      logic [HW_OUT_W-1:0]            hint;
      logic [HW_OUT_W-1:0]            mark;
      logic [SERIAL_W-1:0]            counter;
   } slot_table_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [OP_W-1:0]       req_op = '0;
   logic [HANDLE_W-1:0]   req_handle = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_ok;
   logic [HANDLE_W-1:0]   rsp_new_handle;
   logic [SLOT_OUT_W-1:0] rsp_slot_index;
   logic [HW_OUT_W-1:0]   rsp_high_water;

   generation_handle_slot_allocator #(.SLOTS(SLOTS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_handle     (req_handle),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_new_handle (rsp_new_handle),
      .rsp_slot_index (rsp_slot_index),
      .rsp_high_water (rsp_high_water)
   );

   always #6 clock = ~clock;

   cmd_word_type        pending_cmds[$];
   rsp_word_type        expected_rsp[$];
   logic [HANDLE_W-1:0] live_handles[$];
   logic [HANDLE_W-1:0] dead_handles[$];
   slot_table_type      plan_table;
   slot_table_type      check_table;
   rsp_word_type        oldest_rsp;
   int n_accepted = 0;
   int n_popped   = 0;
   int n_errors   = 0;
   int n_adds     = 0;
   int n_deletes  = 0;
   int n_lookups  = 0;
   int n_full     = 0;
   int n_wraps    = 0;
   int roll_begin = 0;
   int roll_end   = 0;
   bit word_popped;
   bit idle_now;

   function automatic rsp_word_type table_step(inout slot_table_type st,
                                               input logic [OP_W-1:0] op,
                                               input logic [HANDLE_W-1:0] h);
      rsp_word_type r;
      int p;
      int idx;
      bit hit;
      r   = '0;
      idx = int'(h[INDEX_FIELD_W-1:0]);
      hit = 1'b0;
      if (idx < SLOTS) begin
         if (st.live[idx] && st.serial[idx] == h[HANDLE_W-1:INDEX_FIELD_W]) hit = 1'b1;
      end
      case (op)
         OP_ADD: begin
            p = int'(st.hint);
            while (p < SLOTS && st.live[p]) p++;
            if (p < SLOTS) begin
               st.counter   = st.counter + 1'b1;
               st.hint      = HW_OUT_W'(p);
               st.live[p]   = 1'b1;
               st.serial[p] = st.counter;
               if (st.mark < p + 1) st.mark = HW_OUT_W'(p + 1);
               r.ok         = 1'b1;
               r.new_handle = {st.counter, INDEX_FIELD_W'(p)};
               r.slot_index = SLOT_OUT_W'(p);
            end
         end
         OP_DELETE: begin
            if (hit) begin
               st.live[idx] = 1'b0;
               if (idx < st.hint) st.hint = HW_OUT_W'(idx);
               while (st.mark > 1 && st.mark <= SLOTS && !st.live[st.mark - 1])
                  st.mark = st.mark - 1'b1;
               r.ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               r.ok         = 1'b1;
               r.slot_index = SLOT_OUT_W'(idx);
            end
         end
         default: ;
      endcase
      r.high_water = st.mark;
      return r;
   endfunction

   function automatic void plan_word(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] h);
      rsp_word_type r;
      int i;
      pending_cmds.push_back('{op: op, handle: h});
      r = table_step(plan_table, op, h);
      if (op == OP_ADD && r.ok) live_handles.push_back(r.new_handle);
      if (op == OP_DELETE && r.ok) begin
         for (i = 0; i < live_handles.size(); i++) begin
            if (live_handles[i] == h) begin
               live_handles.delete(i);
               dead_handles.push_back(h);
               break;
            end
         end
      end
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_live();
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
   endfunction

   function automatic void random_section(input int count, input int add_pct);
      int n;
      int k;
      logic [HANDLE_W-1:0] h;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < add_pct) begin
            plan_word(OP_ADD, HANDLE_W'($urandom));
         end else begin
            k = $urandom_range(0, 9);
            if (live_handles.size() == 0 && k < 8) k = 8;
            case (k)
               0, 1, 2, 3, 4: plan_word(OP_DELETE, pick_live());
               5, 6: plan_word(OP_LOOKUP, pick_live());
               7: begin
                  h = pick_live();
                  case ($urandom_range(0, 2))
                     0: h = h ^ (31'h1 << (INDEX_FIELD_W + $urandom_range(0, SERIAL_W - 1)));
                     1: h[INDEX_FIELD_W-1:0] = INDEX_FIELD_W'($urandom_range(SLOTS, 16'hFFFF));
                     default: begin
                        if (dead_handles.size() > 0)
                           h = dead_handles[$urandom_range(0, dead_handles.size() - 1)];
                     end
                  endcase
                  plan_word($urandom_range(0, 1) ? OP_DELETE : OP_LOOKUP, h);
               end
               8: plan_word(OP_W'($urandom_range(1, 3)), HANDLE_W'($urandom));
               default: plan_word($urandom_range(0, 1) ? OP_NONE : OP_LOOKUP, HANDLE_W'($urandom));
            endcase
         end
      end
   endfunction

   task automatic check_field(input string field, input logic [HANDLE_W-1:0] exp_v,
                              input logic [HANDLE_W-1:0] act_v);
      if (act_v !== exp_v) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         word_popped = 1'b0;
         if (n_accepted > n_popped) begin
            void'(pending_cmds.pop_front());
            n_popped++;
            word_popped = 1'b1;
         end
         if (!(start && !word_popped)) begin
            idle_now = (n_popped < roll_begin || n_popped >= roll_end) &&
                       ($urandom_range(0, 99) < 18);
            if (pending_cmds.size() > 0 && !idle_now) begin
               start      <= 1'b1;
               req_op     <= pending_cmds[0].op;
               req_handle <= pending_cmds[0].handle;
            end else begin
               start      <= 1'b0;
               req_op     <= OP_W'($urandom);
               req_handle <= HANDLE_W'($urandom);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_rsp.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("%0t: result word with none expected, expected none, actual ok=%0h",
                           $time, rsp_ok);
            end else begin
               oldest_rsp = expected_rsp.pop_front();
               check_field("ok", HANDLE_W'(oldest_rsp.ok), HANDLE_W'(rsp_ok));
               check_field("new_handle", oldest_rsp.new_handle, rsp_new_handle);
               check_field("slot_index", HANDLE_W'(oldest_rsp.slot_index),
                           HANDLE_W'(rsp_slot_index));
               check_field("high_water", HANDLE_W'(oldest_rsp.high_water),
                           HANDLE_W'(rsp_high_water));
            end
         end
         if (start && busy === 1'b0) begin
            oldest_rsp = table_step(check_table, req_op, req_handle);
            expected_rsp.push_back(oldest_rsp);
            n_accepted++;
            if (req_op == OP_ADD && oldest_rsp.ok) n_adds++;
            if (req_op == OP_ADD && !oldest_rsp.ok) n_full++;
            if (req_op == OP_ADD && oldest_rsp.ok && check_table.counter == 0) n_wraps++;
            if (req_op == OP_DELETE && oldest_rsp.ok) n_deletes++;
            if (req_op == OP_LOOKUP && oldest_rsp.ok) n_lookups++;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words accepted", CYCLE_LIMIT, n_accepted);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [HANDLE_W-1:0] h_a, h_b, h_c, h_d;
      int total;
      plan_table  = '0;
      check_table = '0;

      // directed: empty table, unused op, hint reuse, mark descent to 1
      plan_word(OP_LOOKUP, '0);
      plan_word(OP_DELETE, '0);
      plan_word(OP_NONE, 31'h7FFF_FFFF);
      plan_word(OP_ADD, 31'h7FFF_FFFF);
      plan_word(OP_ADD, '0);
      plan_word(OP_ADD, HANDLE_W'($urandom));
      h_a = live_handles[0];
      h_b = live_handles[1];
      h_c = live_handles[2];
      plan_word(OP_LOOKUP, h_b);
      plan_word(OP_LOOKUP, {h_b[HANDLE_W-1:INDEX_FIELD_W], 16'd64});
      plan_word(OP_LOOKUP, {h_b[HANDLE_W-1:INDEX_FIELD_W], 16'hFFFF});
      plan_word(OP_LOOKUP, h_b ^ 31'h1_0000);
      plan_word(OP_DELETE, {~h_b[HANDLE_W-1:INDEX_FIELD_W], h_b[INDEX_FIELD_W-1:0]});
      plan_word(OP_DELETE, h_b);
      plan_word(OP_DELETE, h_b);
      plan_word(OP_LOOKUP, h_b);
      plan_word(OP_ADD, '0);
      h_d = live_handles[$];
      plan_word(OP_DELETE, h_c);
      plan_word(OP_DELETE, h_a);
      plan_word(OP_DELETE, h_d);
      plan_word(OP_LOOKUP, h_a);
      plan_word(OP_ADD, 31'h5555_5555);
      plan_word(OP_NONE, '0);

      random_section(200, 75);
      random_section(200, 25);
      random_section(230, 50);
      random_section(200, 65);
      random_section(180, 35);

      // empty the table, then add/delete pairs with no idling
      while (live_handles.size() > 0) plan_word(OP_DELETE, live_handles[0]);
      plan_word(OP_ADD, '0);
      plan_word(OP_ADD, '0);
      roll_begin = pending_cmds.size();
      repeat (ROLL_PAIRS) begin
         plan_word(OP_ADD, HANDLE_W'($urandom));
         plan_word(OP_DELETE, live_handles[$]);
      end
      roll_end = pending_cmds.size();
      random_section(50, 50);
      total = pending_cmds.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (n_accepted < total) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words: %0d adds, %0d deletes, %0d lookups succeeded", n_accepted, n_adds,
               n_deletes, n_lookups);
      $display("%0d adds refused on a full table, %0d serial wraps, %0d errors", n_full,
               n_wraps, n_errors);
      if (n_errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
